/* hdl/xbr_pkg.sv */
// ----------------------------------------------------------------------------
// xbr_pkg
// Shared types and constants of the XMODEM block receiver.
// ----------------------------------------------------------------------------
package xbr_pkg;

    localparam int unsigned BLOCK_BYTES_DEF = 128;
    localparam int unsigned INTERVAL_W      = 16;
    localparam logic [INTERVAL_W-1:0] NAK_INTERVAL_RST = 16'd50;

    localparam logic [7:0] CH_SOH = 8'h01;
    localparam logic [7:0] CH_EOT = 8'h04;
    localparam logic [7:0] CH_ACK = 8'h06;
    localparam logic [7:0] CH_NAK = 8'h15;

    localparam logic ACT_BYTE  = 1'b0;
    localparam logic ACT_TICK  = 1'b1;
    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_CTRL = 1'b1;

    typedef enum logic [2:0] {
        PH_WAIT,
        PH_HEADER,
        PH_BLKNUM,
        PH_BLKCMP,
        PH_DATA,
        PH_CHECK,
        PH_DONE
    } phase_t;

    typedef struct packed {
        logic       action;
        logic [7:0] rx_byte;
    } item_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] value;
        logic       finished;
    } result_t;

endpackage

/* hdl/xmodem_block_receiver_core.sv */
// A result reaches the master side through the input and result registers.
// Throughput: one input transfer per cycle; the input register frees whenever
// the result register is empty or being drained in the same cycle.
// Reset (aresetn low, synchronous): waiting for the first byte, counters zero,
// nak_interval back to 50, both registers empty.
// ----------------------------------------------------------------------------
// xmodem_block_receiver_core
// Receiver side of a simplified XMODEM transfer, 128-byte blocks by default.
// ----------------------------------------------------------------------------
module xmodem_block_receiver_core
    import xbr_pkg::*;
#(
    parameter int unsigned BLOCK_BYTES = BLOCK_BYTES_DEF
)
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // rx_byte
    input  logic                  s_tuser,   // action
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,   // value
    output logic                  m_tuser,   // kind
    output logic                  m_tlast,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [INTERVAL_W-1:0] cfg_data
);

    item_t   s_item;
    item_t   item;
    logic    item_valid;
    logic    take;
    logic    res_valid;
    logic    res_ready;
    result_t res;
    result_t m_res;

    assign s_item    = '{action: s_tuser, rx_byte: s_tdata};
    assign cfg_ready = 1'b1;
    assign m_tdata   = m_res.value;
    assign m_tuser   = m_res.kind;
    assign m_tlast   = m_res.finished;

    xbr_inreg u_inreg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .s_item     (s_item),
        .item_valid (item_valid),
        .item       (item),
        .take       (take)
    );

    xbr_fsm #(
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_fsm (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_data   (cfg_data),
        .item_valid (item_valid),
        .item       (item),
        .res_ready  (res_ready),
        .take       (take),
        .res_valid  (res_valid),
        .res        (res)
    );

    xbr_outreg u_outreg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_res     (m_res)
    );

endmodule

/* hdl/xbr_inreg.sv */
// ----------------------------------------------------------------------------
// xbr_inreg
// Input register holding one accepted item until the protocol logic takes it.
// ----------------------------------------------------------------------------
module xbr_inreg
    import xbr_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    output logic  s_ready,
    input  item_t s_item,
    output logic  item_valid,
    output item_t item,
    input  logic  take
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign s_ready    = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

endmodule

/* hdl/xbr_fsm.sv */
// ----------------------------------------------------------------------------
// xbr_fsm
// Protocol state machine: NAK timer, block framing and result generation.
// ----------------------------------------------------------------------------
module xbr_fsm
    import xbr_pkg::*;
#(
    parameter int unsigned BLOCK_BYTES = BLOCK_BYTES_DEF
)
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    input  logic [INTERVAL_W-1:0] cfg_data,
    input  logic                  item_valid,
    input  item_t                 item,
    input  logic                  res_ready,
    output logic                  take,
    output logic                  res_valid,
    output result_t               res
);

    localparam int unsigned CNT_W = $clog2(BLOCK_BYTES);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(BLOCK_BYTES - 1);

    phase_t                phase_reg;
    phase_t                phase_next;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic [INTERVAL_W-1:0] tick_reg;
    logic [INTERVAL_W-1:0] tick_next;
    logic [INTERVAL_W-1:0] interval_reg;
    logic [INTERVAL_W-1:0] tick_inc;
    logic                  emit;

    assign take      = item_valid && res_ready;
    assign res_valid = take && emit;
    assign tick_inc  = tick_reg + INTERVAL_W'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            interval_reg <= NAK_INTERVAL_RST;
        end else if (cfg_valid) begin
            interval_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_WAIT;
            count_reg <= '0;
            tick_reg  <= '0;
        end else begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            tick_reg  <= tick_next;
        end
    end

    always_comb begin
        phase_next = phase_reg;
        count_next = count_reg;
        tick_next  = tick_reg;
        emit       = 1'b0;
        res        = '{kind: KIND_CTRL, value: CH_NAK, finished: 1'b0};
        if (take && phase_reg != PH_DONE) begin
            if (item.action == ACT_TICK) begin
                if (phase_reg == PH_WAIT) begin
                    tick_next = tick_inc;
                    if (tick_inc >= interval_reg) begin
                        tick_next = '0;
                        emit      = 1'b1;
                    end
                end
            end else begin
                unique case (phase_reg)
                    PH_WAIT, PH_HEADER: begin
                        priority if (item.rx_byte == CH_SOH) begin
                            phase_next = PH_BLKNUM;
                        end else if (item.rx_byte == CH_EOT) begin
                            phase_next   = PH_DONE;
                            emit         = 1'b1;
                            res.value    = CH_ACK;
                            res.finished = 1'b1;
                        end else begin
                            phase_next = PH_HEADER;
                            emit       = 1'b1;
                        end
                    end
                    PH_BLKNUM: begin
                        count_next = '0;
                        phase_next = PH_BLKCMP;
                    end
                    PH_BLKCMP: begin
                        phase_next = PH_DATA;
                    end
                    PH_DATA: begin
                        emit      = 1'b1;
                        res.kind  = KIND_DATA;
                        res.value = item.rx_byte;
                        if (count_reg == CNT_LAST) begin
                            count_next = '0;
                            phase_next = PH_CHECK;
                        end else begin
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    PH_CHECK: begin
                        phase_next = PH_HEADER;
                        emit       = 1'b1;
                        res.value  = CH_ACK;
                    end
                    default: begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end
    end

    a_fin_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && res.finished |=> phase_reg == PH_DONE)
        else $error("finishing ack did not close the session");

    a_done_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_DONE |-> !res_valid)
        else $error("result after session end");

    a_count_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg != PH_DATA |-> count_reg == '0)
        else $error("data count nonzero outside data phase");

    a_data_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && res.kind == KIND_DATA |-> phase_reg == PH_DATA)
        else $error("data result outside data phase");

endmodule

/* hdl/xbr_outreg.sv */
// ----------------------------------------------------------------------------
// xbr_outreg
// Result register on the master side, loaded while empty or draining.
// ----------------------------------------------------------------------------
module xbr_outreg
    import xbr_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    res_valid,
    output logic    res_ready,
    input  result_t res,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t m_res
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign res_ready = !valid_reg || m_ready;
    assign m_valid   = valid_reg;
    assign m_res     = res_reg;

    always_comb begin
        valid_next = valid_reg;
        if (res_valid && res_ready) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            res_reg <= res;
        end
    end

endmodule

/* tb/xbr_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// xbr_checker
// Watches the input, result and interval channels of the XMODEM block
// receiver, predicts the reply to every accepted input transfer and compares
// each result transfer field by field against the oldest reply still due.
// ----------------------------------------------------------------------------
module xbr_checker
    import xbr_pkg::*;
#(
    parameter int unsigned BLOCK_BYTES = BLOCK_BYTES_DEF
)
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [7:0]            s_tdata,
    input  logic                  s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [7:0]            m_tdata,
    input  logic                  m_tuser,
    input  logic                  m_tlast,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [INTERVAL_W-1:0] cfg_data,
    output int                    mismatches,
    output int                    pending,
    output int                    items_seen,
    output int                    replies_seen,
    output int                    bytes_stored
);

    phase_t                ph;
    int unsigned           byte_idx;
    logic [INTERVAL_W-1:0] ticks;
    logic [INTERVAL_W-1:0] interval;
    result_t               replies_due[$];

    function automatic logic receiver_reply(input logic act, input logic [7:0] rx,
                                            output result_t rsp);
        rsp = '0;
        if (ph == PH_DONE)
            return 1'b0;
        if (act == ACT_TICK) begin
            if (ph != PH_WAIT)
                return 1'b0;
            ticks = ticks + 1'b1;
            if (ticks < interval)
                return 1'b0;
            ticks = '0;
            rsp = {KIND_CTRL, CH_NAK, 1'b0};
            return 1'b1;
        end
        case (ph)
            PH_WAIT, PH_HEADER: begin
                if (rx == CH_SOH) begin
                    ph = PH_BLKNUM;
                    return 1'b0;
                end
                if (rx == CH_EOT) begin
                    ph = PH_DONE;
                    rsp = {KIND_CTRL, CH_ACK, 1'b1};
                    return 1'b1;
                end
                ph = PH_HEADER;
                rsp = {KIND_CTRL, CH_NAK, 1'b0};
                return 1'b1;
            end
            PH_BLKNUM: begin
                byte_idx = 0;
                ph = PH_BLKCMP;
                return 1'b0;
            end
            PH_BLKCMP: begin
                ph = PH_DATA;
                return 1'b0;
            end
            PH_DATA: begin
                if (byte_idx + 1 >= BLOCK_BYTES) begin
                    byte_idx = 0;
                    ph = PH_CHECK;
                end else begin
                    byte_idx++;
                end
                rsp = {KIND_DATA, rx, 1'b0};
                return 1'b1;
            end
            PH_CHECK: begin
                ph = PH_HEADER;
                rsp = {KIND_CTRL, CH_ACK, 1'b0};
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    task automatic check_field(input string name, input logic [7:0] want_v,
                               input logic [7:0] got_v);
        if (got_v !== want_v) begin
            $error("%s mismatch: expected 0x%02h, actual 0x%02h", name, want_v, got_v);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (!aresetn) begin
            ph = PH_WAIT;
            byte_idx = 0;
            ticks = '0;
            interval = NAK_INTERVAL_RST;
            replies_due.delete();
        end else begin
            if (cfg_valid && cfg_ready)
                interval = cfg_data;
            if (m_tvalid && m_tready) begin
                replies_seen++;
                got = {m_tuser, m_tdata, m_tlast};
                if (replies_due.size() == 0) begin
                    $error("unexpected result: kind %0d value 0x%02h finished %0d",
                           got.kind, got.value, got.finished);
                    mismatches++;
                end else begin
                    want = replies_due.pop_front();
                    check_field("kind", 8'(want.kind), 8'(got.kind));
                    check_field("value", want.value, got.value);
                    check_field("finished", 8'(want.finished), 8'(got.finished));
                end
            end
            if (s_tvalid && s_tready) begin
                items_seen++;
                if (receiver_reply(s_tuser, s_tdata, want)) begin
                    replies_due.push_back(want);
                    if (want.kind == KIND_DATA)
                        bytes_stored++;
                end
            end
        end
        pending <= replies_due.size();
    end

endmodule

/* tb/tb_xmodem_block_receiver_core.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_xmodem_block_receiver_core
// Drives one XMODEM session into the block receiver: NAK timing at several
// intervals while waiting, stray header bytes, full blocks with random and
// control-code content, ignored ticks, the closing EOT and inputs after it.
// ----------------------------------------------------------------------------
module tb_xmodem_block_receiver_core;
    import xbr_pkg::*;

    localparam int unsigned BLOCK_BYTES  = BLOCK_BYTES_DEF;
    localparam int          RAND_ITEMS   = 1100;
    localparam int          LIMIT_CYCLES = 1000000;
    localparam int          HOLD_CYCLES  = 300;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata   = '0;
    logic                  s_tuser   = ACT_BYTE;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [7:0]            m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [INTERVAL_W-1:0] cfg_data  = '0;

    int mismatch_count;
    int replies_pending;
    int items_taken;
    int replies_taken;
    int bytes_stored;

    int src_idle_pct = 32;
    int snk_idle_pct = 84;
    int hold_trigger = 0;
    int hold_seen    = 0;
    int hold_left    = 0;
    int cycles       = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    xmodem_block_receiver_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    xbr_checker u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .m_tlast      (m_tlast),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .mismatches   (mismatch_count),
        .pending      (replies_pending),
        .items_seen   (items_taken),
        .replies_seen (replies_taken),
        .bytes_stored (bytes_stored)
    );

    // result side: random stalls, plus one long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else if (hold_trigger != hold_seen) begin
            hold_seen = hold_trigger;
            hold_left = HOLD_CYCLES;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $error("timeout after %0d cycles", cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic send_item(input logic act, input logic [7:0] b);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= b;
        do
            @(posedge aclk);
        while (!s_tready);
    endtask

    task automatic send_ticks(input int n);
        repeat (n) send_item(ACT_TICK, 8'($urandom_range(255)));
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (replies_pending != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_interval(input logic [INTERVAL_W-1:0] v);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge aclk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] control_code(input int k);
        case (k)
            0:       return CH_SOH;
            1:       return CH_EOT;
            2:       return CH_ACK;
            default: return CH_NAK;
        endcase
    endfunction

    function automatic logic [7:0] random_byte();
        if ($urandom_range(7) == 0)
            return control_code($urandom_range(3));
        return 8'($urandom_range(255));
    endfunction

    task automatic send_block(input bit directed);
        logic [7:0] b;
        send_item(ACT_BYTE, CH_SOH);
        send_item(ACT_BYTE, directed ? CH_EOT : random_byte());
        send_item(ACT_BYTE, directed ? CH_SOH : random_byte());
        for (int i = 0; i < BLOCK_BYTES; i++) begin
            if (directed && i == 0)
                b = 8'h00;
            else if (directed && i == 1)
                b = 8'hFF;
            else if (directed && i < 6)
                b = control_code(i - 2);
            else
                b = random_byte();
            if ($urandom_range(49) == 0)
                send_item(ACT_TICK, 8'($urandom_range(255)));
            send_item(ACT_BYTE, b);
        end
        send_item(ACT_BYTE, directed ? 8'hFF : random_byte());
    endtask

    initial begin
        int         n_rand;
        int         mode;
        int         pick;
        logic [7:0] b;

        n_rand = 0;
        mode   = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // waiting for the sender: NAK spacing at several intervals
        send_ticks(120);
        write_interval(16'd1);
        send_ticks(5);
        write_interval(16'd0);
        send_ticks(4);
        write_interval(16'hFFFF);
        send_ticks(100);
        // lowered below the running count
        write_interval(16'd7);
        send_ticks(10);
        write_interval(INTERVAL_W'($urandom_range(200, 2)));
        send_ticks($urandom_range(120, 20));
        drain_results();

        // header phase: stray bytes, ignored ticks, two blocks of edge values
        send_item(ACT_BYTE, 8'hFF);
        send_ticks(3);
        send_item(ACT_BYTE, 8'h00);
        send_item(ACT_BYTE, CH_NAK);
        send_item(ACT_BYTE, CH_ACK);
        send_block(1'b1);
        send_item(ACT_BYTE, 8'h7F);
        send_block(1'b1);

        while (n_rand < RAND_ITEMS) begin
            if (mode == 0 && n_rand >= 350) begin
                mode = 1;
                write_interval(INTERVAL_W'($urandom_range(65535, 1)));
                src_idle_pct = 84;
                snk_idle_pct = 32;
            end else if (mode == 1 && n_rand >= 700) begin
                mode = 2;
                write_interval(NAK_INTERVAL_RST);
                src_idle_pct = 0;
                snk_idle_pct = 0;
                hold_trigger <= hold_trigger + 1;
                send_block(1'b0);
                n_rand += BLOCK_BYTES + 4;
            end
            pick = $urandom_range(99);
            if (pick <= 81) begin
                send_block(1'b0);
                n_rand += BLOCK_BYTES + 4;
            end else if (pick <= 93) begin
                do
                    b = 8'($urandom_range(255));
                while (b == CH_SOH || b == CH_EOT);
                send_item(ACT_BYTE, b);
                n_rand++;
            end else begin
                send_ticks($urandom_range(6, 1));
            end
        end

        // close the session, then inputs that must draw nothing
        send_item(ACT_BYTE, CH_EOT);
        send_item(ACT_BYTE, CH_SOH);
        send_item(ACT_BYTE, CH_EOT);
        send_ticks(4);
        send_item(ACT_BYTE, 8'hA5);
        drain_results();
        repeat (16) @(posedge aclk);

        $display("run covered %0d input transfers and %0d result transfers, %0d of them data",
                 items_taken, replies_taken, bytes_stored);
        $display("NAK intervals 50, 1, 0, 65535, 7 and random; one long result hold-off");
        if (mismatch_count == 0 && replies_pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

/* filelist.f */
hdl/xbr_pkg.sv
hdl/xbr_inreg.sv
hdl/xbr_fsm.sv
hdl/xbr_outreg.sv
hdl/xmodem_block_receiver_core.sv
tb/xbr_checker.sv
tb/tb_xmodem_block_receiver_core.sv
